// ===== hdl/htb_pkg.sv =====
// ----------------------------------------------------------------------------
// htb_pkg
// Shared widths, types, register indexes and the hex digit decoder for the
// hex text to binary unit.
// ----------------------------------------------------------------------------
package htb_pkg;

   localparam int MAX_OUT_BYTES = 64;
   localparam int MAX_HEX_CHARS = 4096;

   localparam int CHAR_W  = 8;
   localparam int LEN_W   = 13;
   localparam int CNT_W   = 7;
   localparam int NIB_W   = 4;
   localparam int IDX_W   = 2;
   localparam int CSR_W   = 7;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 2;

   localparam logic [IDX_W-1:0] CSR_TRIM_LEADING_ZEROS = 2'd0;
   localparam logic [IDX_W-1:0] CSR_ZERO_AS_EMPTY      = 2'd1;
   localparam logic [IDX_W-1:0] CSR_OUT_CAPACITY       = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_X = 8'h78;
   localparam logic [NIB_W-1:0]  NIBBLE_TEN   = 4'hA;

   localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(MAX_OUT_BYTES);

   typedef struct packed {
      logic              trim_leading_zeros;
      logic              zero_as_empty;
      logic [CNT_W-1:0]  out_capacity;
   } cfg_type;

   typedef struct packed {
      logic [CHAR_W-1:0] hex_char;
      logic [LEN_W-1:0]  string_length;
      logic              last_char;
   } item_type;

   typedef struct packed {
      logic              produce;
      logic [CHAR_W-1:0] data_byte;
      logic              byte_valid;
      logic              end_of_string;
      logic              error_flag;
      logic [CNT_W-1:0]  byte_count;
   } result_type;

   typedef struct packed {
      logic              is_hex;
      logic [NIB_W-1:0]  value;
   } nibble_type;

   function automatic nibble_type nibble_of(input logic [CHAR_W-1:0] c);
      nibble_type n;
      n.is_hex = 1'b1;
      n.value  = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         n.value = NIB_W'(c - CHAR_ZERO);
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         n.value = NIB_W'(c - CHAR_UPPER_A) + NIBBLE_TEN;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         n.value = NIB_W'(c - CHAR_LOWER_A) + NIBBLE_TEN;
      end else begin
         n.is_hex = 1'b0;
      end
      return n;
   endfunction

endpackage

// ===== hdl/hex_text_to_binary_unit.sv =====
// ----------------------------------------------------------------------------
// hex_text_to_binary_unit
// Streaming decoder from hex character strings to bytes.
//
// Usage: one character per req transaction (tdata holds the character and
// the string length, tlast marks the last character). Each rsp transaction
// carries a decoded byte and/or the close of a string; tlast marks the close,
// which also reports the error flag and the byte count. Characters that
// produce neither a byte nor a close give no rsp transaction.
// Configuration goes through the csr write port while the unit is idle.
// An accepted character is captured in the input register, then decoded
// into the result register, from which the result is presented on rsp.
// Throughput: one character per cycle while rsp does not stall; the
// per-string state in the decode stage is updated for each character.
// Stall: while rsp_tready is low and a result is held, the input register
// holds its character and req_tready drops once that register is full.
// Reset: clears all per-string state and both register stages, and returns
// the configuration to no trimming, zero byte for empty, capacity 64.
// ----------------------------------------------------------------------------
module hex_text_to_binary_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [htb_pkg::IDX_W-1:0]       csr_index,
   input  logic [htb_pkg::CSR_W-1:0]       csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // hex_char[7:0], string_length[20:8], zero pad [23:21]
   input  logic [htb_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // data_byte[7:0], byte_count[14:8], zero pad [15]
   output logic [htb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // byte_valid[0], error_flag[1]
   output logic [htb_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                            rsp_tlast
);
   import htb_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff, in_valid_in;
   item_type   item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type result;
   logic       out_free;
   logic       advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trim_leading_zeros <= 1'b0;
         cfg_ff.zero_as_empty      <= 1'b0;
         cfg_ff.out_capacity       <= CAPACITY_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TRIM_LEADING_ZEROS: cfg_ff.trim_leading_zeros <= csr_wdata[0];
            CSR_ZERO_AS_EMPTY:      cfg_ff.zero_as_empty      <= csr_wdata[0];
            CSR_OUT_CAPACITY:       cfg_ff.out_capacity       <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? result.produce : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.hex_char      <= req_tdata[CHAR_W-1:0];
         item_ff.string_length <= req_tdata[CHAR_W +: LEN_W];
         item_ff.last_char     <= req_tlast;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   htb_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.byte_count, out_ff.data_byte};
   assign rsp_tuser  = {out_ff.error_flag, out_ff.byte_valid};
   assign rsp_tlast  = out_ff.end_of_string;

   a_error_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.error_flag |->
         out_ff.end_of_string && !out_ff.byte_valid && out_ff.byte_count == '0)
      else $error("error result must close the string with no byte and zero count");

   a_open_has_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !out_ff.end_of_string |-> out_ff.byte_valid && !out_ff.error_flag)
      else $error("result that does not close a string must carry a byte");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.end_of_string |-> out_ff.byte_count <= CNT_W'(MAX_OUT_BYTES))
      else $error("byte count exceeds capacity limit");

   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(item_ff))
      else $error("stalled character left the input register");

endmodule

// ===== hdl/htb_core.sv =====
// ----------------------------------------------------------------------------
// htb_core
// Per-string decode state and the single-pass next-state and result logic
// for one character transaction.
// ----------------------------------------------------------------------------
module htb_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  htb_pkg::item_type   item,
   input  htb_pkg::cfg_type    cfg,
   output htb_pkg::result_type result
);
   import htb_pkg::*;

   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [NIB_W-1:0] high_ff, high_in;
   logic             first_kept_ff, first_kept_in;
   logic [CNT_W-1:0] bytes_ff, bytes_in;
   logic             stopped_ff, stopped_in;
   logic             error_ff, error_in;
   logic             deferred_ff, deferred_in;

   nibble_type        nib;
   logic              active;
   logic              odd;
   logic              zero_offer;
   logic              pair_offer;
   logic [CHAR_W-1:0] pair_byte;
   logic              zero_take;
   logic              pair_take;
   logic              kept_mid;
   logic [CNT_W-1:0]  bytes_mid;
   logic              stopped_mid;
   logic [CNT_W-1:0]  cap;

   always_comb begin
      priority if (cfg.out_capacity == '0) begin
         cap = CNT_W'(1);
      end else if (cfg.out_capacity > CNT_W'(MAX_OUT_BYTES)) begin
         cap = CNT_W'(MAX_OUT_BYTES);
      end else begin
         cap = cfg.out_capacity;
      end
   end

   always_comb begin
      nib          = nibble_of(item.hex_char);
      odd          = item.string_length[0];
      active       = (item.string_length != '0) && (pos_ff < item.string_length) &&
                     (pos_ff < LEN_W'(MAX_HEX_CHARS)) && !stopped_ff && !error_ff;
      zero_offer   = 1'b0;
      pair_offer   = 1'b0;
      pair_byte    = {high_ff, nib.value};
      high_in      = high_ff;
      error_in     = error_ff;
      deferred_in  = deferred_ff;

      if (active) begin
         priority if (pos_ff == LEN_W'(1) && deferred_ff &&
                      (item.hex_char == CHAR_LOWER_X || item.hex_char == CHAR_UPPER_X)) begin
            deferred_in = 1'b0;
         end else if (!nib.is_hex) begin
            error_in    = 1'b1;
            deferred_in = 1'b0;
         end else if (pos_ff == '0 && item.string_length > LEN_W'(2) &&
                      item.hex_char == CHAR_ZERO && !item.last_char) begin
            deferred_in = 1'b1;
            high_in     = '0;
         end else begin
            if (deferred_ff) begin
               deferred_in = 1'b0;
               if (odd) begin
                  zero_offer = 1'b1;
               end
            end
            if (pos_ff[0] == odd) begin
               high_in = nib.value;
            end else begin
               pair_offer = 1'b1;
            end
         end
      end

      zero_take     = zero_offer && !(cfg.trim_leading_zeros && !first_kept_ff);
      kept_mid      = first_kept_ff || zero_take;
      bytes_mid     = zero_take ? bytes_ff + CNT_W'(1) : bytes_ff;
      stopped_mid   = stopped_ff || (zero_take && bytes_mid >= cap);
      pair_take     = pair_offer && !stopped_mid &&
                      !(cfg.trim_leading_zeros && !kept_mid && pair_byte == '0);
      first_kept_in = kept_mid || pair_take;
      bytes_in      = pair_take ? bytes_mid + CNT_W'(1) : bytes_mid;
      stopped_in    = stopped_mid || (pair_take && bytes_in >= cap);

      pos_in = (pos_ff == '1) ? pos_ff : pos_ff + LEN_W'(1);

      result.produce       = zero_take || pair_take || item.last_char;
      result.data_byte     = pair_take ? pair_byte : '0;
      result.byte_valid    = zero_take || pair_take;
      result.end_of_string = item.last_char;
      result.error_flag    = 1'b0;
      result.byte_count    = '0;

      if (item.last_char) begin
         priority if (error_in) begin
            result.data_byte  = '0;
            result.byte_valid = 1'b0;
            result.error_flag = 1'b1;
         end else if (bytes_in == '0 && !cfg.zero_as_empty) begin
            result.data_byte  = '0;
            result.byte_valid = 1'b1;
            result.byte_count = CNT_W'(1);
         end else begin
            result.byte_count = bytes_in;
         end
         pos_in        = '0;
         high_in       = '0;
         first_kept_in = 1'b0;
         bytes_in      = '0;
         stopped_in    = 1'b0;
         error_in      = 1'b0;
         deferred_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         high_ff       <= '0;
         first_kept_ff <= 1'b0;
         bytes_ff      <= '0;
         stopped_ff    <= 1'b0;
         error_ff      <= 1'b0;
         deferred_ff   <= 1'b0;
      end else if (fire) begin
         pos_ff        <= pos_in;
         high_ff       <= high_in;
         first_kept_ff <= first_kept_in;
         bytes_ff      <= bytes_in;
         stopped_ff    <= stopped_in;
         error_ff      <= error_in;
         deferred_ff   <= deferred_in;
      end
   end

endmodule

// ===== tb/hex_text_to_binary_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_text_to_binary_unit_tb
// Self-checking bench for the hex text to binary unit. Hex strings go in one
// character per transaction with random bursts and gaps. A behavioral decoder
// predicts each response, and every response is checked field by field in
// arrival order. The run covers directed strings (prefix, odd length, errors,
// empty, early and late close), random strings under several register
// settings, a long receiver stall and one long string closed before its
// stated length.
// ----------------------------------------------------------------------------
module hex_text_to_binary_unit_tb;
   import htb_pkg::*;

   localparam logic [IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [LEN_W-1:0] LEN_ALL_ONES = '1;

   typedef struct packed {
      logic [CHAR_W-1:0] data_byte;
      logic              byte_valid;
      logic              end_of_string;
      logic              error_flag;
      logic [CNT_W-1:0]  byte_count;
   } decoded_type;

   typedef logic [CHAR_W-1:0] text_type[$];

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [IDX_W-1:0]      csr_index = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   // decoder model: configuration and per-string state
   logic             trim_cfg = 1'b0;
   logic             empty_cfg = 1'b0;
   logic [CNT_W-1:0] cap_cfg = CAPACITY_RESET;
   logic [LEN_W-1:0] char_pos = '0;
   logic [NIB_W-1:0] high_nib = '0;
   logic             first_kept = 1'b0;
   logic [CNT_W-1:0] bytes_made = '0;
   logic             cap_reached = 1'b0;
   logic             bad_char_seen = 1'b0;
   logic             zero_held = 1'b0;

   decoded_type expected_out[$];
   int          mismatches = 0;
   int          chars_sent = 0;
   int          burst_left = 0;
   int          hold_request = 0;

   hex_text_to_binary_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

   function automatic logic [CHAR_W-1:0] pick_digit();
      string digits;
      digits = "0123456789abcdefABCDEF";
      if ($urandom_range(0, 3) == 0) begin
         return CHAR_ZERO;
      end
      return digits[$urandom_range(0, digits.len() - 1)];
   endfunction

   function automatic logic offer_byte(input logic [CHAR_W-1:0] b);
      int cap;
      cap = cap_cfg;
      if (cap == 0) begin
         cap = 1;
      end
      if (cap > MAX_OUT_BYTES) begin
         cap = MAX_OUT_BYTES;
      end
      if (trim_cfg && !first_kept && b == '0) begin
         return 1'b0;
      end
      first_kept = 1'b1;
      bytes_made = bytes_made + 1'b1;
      if (bytes_made >= cap) begin
         cap_reached = 1'b1;
      end
      return 1'b1;
   endfunction

   task automatic decode_char(input logic [CHAR_W-1:0] c, input logic [LEN_W-1:0] len,
                              input logic last);
      decoded_type       r;
      logic              emitted;
      logic [CHAR_W-1:0] b;
      logic              odd;
      logic              is_hex;
      logic [NIB_W-1:0]  val;
      logic [CHAR_W-1:0] pair;
      emitted = 1'b0;
      b = '0;
      odd = len[0];
      is_hex = 1'b1;
      val = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         val = NIB_W'(c - CHAR_ZERO);
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         val = NIB_W'(c - CHAR_UPPER_A) + NIBBLE_TEN;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         val = NIB_W'(c - CHAR_LOWER_A) + NIBBLE_TEN;
      end else begin
         is_hex = 1'b0;
      end
      if (len != 0 && char_pos < len && char_pos < MAX_HEX_CHARS && !cap_reached &&
          !bad_char_seen) begin
         if (char_pos == 1 && zero_held && (c == CHAR_LOWER_X || c == CHAR_UPPER_X)) begin
            zero_held = 1'b0;
         end else if (!is_hex) begin
            bad_char_seen = 1'b1;
            zero_held = 1'b0;
         end else if (char_pos == 0 && len > 2 && c == CHAR_ZERO && !last) begin
            zero_held = 1'b1;
            high_nib = '0;
         end else begin
            if (zero_held) begin
               zero_held = 1'b0;
               if (odd && offer_byte('0)) begin
                  emitted = 1'b1;
                  b = '0;
               end
            end
            if (char_pos[0] == odd) begin
               high_nib = val;
            end else if (!cap_reached) begin
               pair = {high_nib, val};
               if (offer_byte(pair)) begin
                  emitted = 1'b1;
                  b = pair;
               end
            end
         end
      end
      if (char_pos != LEN_ALL_ONES) begin
         char_pos = char_pos + 1'b1;
      end
      r = '0;
      if (emitted) begin
         r.data_byte = b;
         r.byte_valid = 1'b1;
      end
      if (last) begin
         r.end_of_string = 1'b1;
         if (bad_char_seen) begin
            r.data_byte = '0;
            r.byte_valid = 1'b0;
            r.error_flag = 1'b1;
         end else if (bytes_made == 0 && !empty_cfg) begin
            r.data_byte = '0;
            r.byte_valid = 1'b1;
            r.byte_count = CNT_W'(1);
         end else begin
            r.byte_count = bytes_made;
         end
         char_pos = '0;
         high_nib = '0;
         first_kept = 1'b0;
         bytes_made = '0;
         cap_reached = 1'b0;
         bad_char_seen = 1'b0;
         zero_held = 1'b0;
      end
      if (emitted || last) begin
         expected_out.push_back(r);
      end
   endtask

   // sender: bursts of random length separated by random gaps
   task automatic send_char(input logic [CHAR_W-1:0] c, input logic [LEN_W-1:0] len,
                            input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, len, c};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      decode_char(c, len, last);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input text_type text, input logic [LEN_W-1:0] len,
                            input logic close);
      for (int i = 0; i < text.size(); i++) begin
         send_char(text[i], len, close && i == text.size() - 1);
      end
   endtask

   task automatic send_string(input string s);
      text_type text;
      for (int i = 0; i < s.len(); i++) begin
         text.push_back(s[i]);
      end
      send_text(text, LEN_W'(s.len()), 1'b1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_out.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_config(input logic trim, input logic empty, input logic [CNT_W-1:0] cap);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TRIM_LEADING_ZEROS;
      csr_wdata <= {6'($urandom), trim};
      @(negedge clock);
      csr_index <= CSR_ZERO_AS_EMPTY;
      csr_wdata <= {6'($urandom), empty};
      @(negedge clock);
      csr_index <= CSR_OUT_CAPACITY;
      csr_wdata <= cap;
      @(negedge clock);
      csr_index <= CSR_UNUSED;
      csr_wdata <= 7'($urandom);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      trim_cfg = trim;
      empty_cfg = empty;
      cap_cfg = cap;
   endtask

   task automatic send_random_string();
      text_type text;
      int       kind;
      int       r;
      int       len;
      int       delta;
      logic     close;
      kind = $urandom_range(0, 9);
      r = $urandom_range(0, 19);
      close = 1'b1;
      if (r < 14) begin
         len = $urandom_range(1, 10);
      end else if (r < 19) begin
         len = $urandom_range(11, 40);
      end else begin
         len = $urandom_range(100, 140);
      end
      repeat (len) text.push_back(pick_digit());
      if (len > 2 && $urandom_range(0, 2) == 0) begin
         text[0] = CHAR_ZERO;
         text[1] = $urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X;
      end
      case (kind)
         7: begin
            text[$urandom_range(0, len - 1)] = 8'($urandom);
         end
         8: begin
            delta = int'($urandom_range(0, 6)) - 3;
            while (delta < 0 && text.size() > 1) begin
               void'(text.pop_back());
               delta++;
            end
            repeat (delta) text.push_back(pick_digit());
         end
         9: begin
            len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8191);
            text.delete();
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom));
            close = 1'($urandom_range(0, 1));
         end
         default: ;
      endcase
      send_text(text, LEN_W'(len), close);
   endtask

   task automatic test_random_strings(input int count);
      int start;
      start = chars_sent;
      while (chars_sent - start < count) send_random_string();
   endtask

   task automatic test_prefix_and_parity();
      send_string("0x1F");
      send_string("abc");
      send_string("0A5");
      send_string("9F");
   endtask

   task automatic test_bad_chars();
      send_char(8'hFF, 13'd1, 1'b1);
      send_char("1", 13'd3, 1'b0);
      send_char(8'h00, 13'd3, 1'b0);
      send_char("3", 13'd3, 1'b1);
   endtask

   task automatic test_length_edges();
      send_char("5", 13'd0, 1'b1);
      send_char("1", 13'd4, 1'b0);
      send_char("2", 13'd4, 1'b1);
      send_char("1", 13'd2, 1'b0);
      send_char("2", 13'd2, 1'b0);
      send_char("3", 13'd2, 1'b1);
      send_char("7", LEN_ALL_ONES, 1'b1);
   endtask

   task automatic test_config_sweep();
      logic             trims[6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      logic             empties[6] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
      logic [CNT_W-1:0] caps[6] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd65};
      for (int i = 0; i < 8; i++) begin
         wait_drained();
         if (i < 6) begin
            write_config(trims[i], empties[i], caps[i]);
         end else begin
            write_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 7'($urandom));
         end
         test_random_strings(75);
      end
   endtask

   task automatic test_backpressure();
      wait_drained();
      write_config(1'b0, 1'b0, CAPACITY_RESET);
      hold_request = 300;
      test_random_strings(60);
   endtask

   task automatic test_long_string();
      wait_drained();
      write_config(1'b1, 1'($urandom_range(0, 1)), CAPACITY_RESET);
      for (int i = 0; i < 120; i++) begin
         send_char((i < 40) ? CHAR_ZERO : pick_digit(), LEN_ALL_ONES, i == 119);
      end
   endtask

   // receiver: own stall pattern, plus long holds on request
   initial begin
      logic [15:0] pattern;
      int          phase;
      int          hold_left;
      pattern = '1;
      phase = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            if (phase == 0) begin
               pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            end
            rsp_tready <= pattern[phase];
            phase = (phase + 1) % 16;
         end
      end
   end

   always @(posedge clock) begin
      decoded_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_out.size() == 0) begin
            $error("unexpected response: tdata %0h tuser %0h tlast %0b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            mismatches++;
         end else begin
            want = expected_out.pop_front();
            if (rsp_tdata[7:0] !== want.data_byte) begin
               $error("data_byte: expected %0h, actual %0h", want.data_byte, rsp_tdata[7:0]);
               mismatches++;
            end
            if (rsp_tuser[0] !== want.byte_valid) begin
               $error("byte_valid: expected %0h, actual %0h", want.byte_valid, rsp_tuser[0]);
               mismatches++;
            end
            if (rsp_tlast !== want.end_of_string) begin
               $error("end_of_string: expected %0h, actual %0h", want.end_of_string, rsp_tlast);
               mismatches++;
            end
            if (rsp_tuser[1] !== want.error_flag) begin
               $error("error_flag: expected %0h, actual %0h", want.error_flag, rsp_tuser[1]);
               mismatches++;
            end
            if (rsp_tdata[14:8] !== want.byte_count) begin
               $error("byte_count: expected %0h, actual %0h", want.byte_count, rsp_tdata[14:8]);
               mismatches++;
            end
         end
      end
   end

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_prefix_and_parity();
      test_bad_chars();
      test_length_edges();
      test_config_sweep();
      test_backpressure();
      test_long_string();
      wait_drained();
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
